@@ hdl/knpat_pkg.sv @@
// Shared types, codes and constants of the knock pattern recorder and matcher.
`default_nettype none

package knpat_pkg;

  localparam int MAX_INTERVALS_DEF = 16;

  localparam int TICK_W     = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int TOL_W      = 14;
  localparam int DEBOUNCE_W = 10;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0] CHECK_DEBOUNCE = 16'd50;
  localparam logic [TICK_W-1:0] ELAPSED_MAX    = 16'hFFFF;

  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST   = 16'd2000;
  localparam logic [TOL_W-1:0]      TOLERANCE_RST = 14'd200;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 10'd50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS     = 2'd2;

  // Command codes; the unused code behaves as a record tick.
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd2;

  typedef enum logic [1:0] {
    REC_IDLE    = 2'd0,
    REC_FIRST   = 2'd1,
    REC_RELEASE = 2'd2,
    REC_NEXT    = 2'd3
  } rec_phase_e;

  typedef enum logic [1:0] {
    CHK_FIRST   = 2'd0,
    CHK_RELEASE = 2'd1,
    CHK_NEXT    = 2'd2
  } chk_phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHECKING    = 3'd0,
    ST_NO_KNOCKING = 3'd1,
    ST_NO_PATTERN  = 3'd2,
    ST_FAIL        = 3'd3,
    ST_SUCCESS     = 3'd4,
    ST_RECORDING   = 3'd5,
    ST_REC_DONE    = 3'd6,
    ST_REC_FAILED  = 3'd7
  } status_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  press_timeout;
    logic [TOL_W-1:0]      interval_tolerance;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/knpat_in_if.sv @@
// Input channel: one tick transaction with command and sensor level.
`default_nettype none

interface knpat_in_if;
  logic                       valid;
  logic                       ready;
  logic [knpat_pkg::CMD_W-1:0] command;
  logic                       knock;

  modport source (output valid, output command, output knock, input ready);
  modport sink (input valid, input command, input knock, output ready);
endinterface

`default_nettype wire

@@ hdl/knpat_out_if.sv @@
// Output channel: one result transaction per tick.
`default_nettype none

interface knpat_out_if #(
  parameter int MAX_INTERVALS = knpat_pkg::MAX_INTERVALS_DEF
);
  localparam int CntW = $clog2(MAX_INTERVALS + 1);

  logic                          valid;
  logic                          ready;
  logic [knpat_pkg::STATUS_W-1:0] status;
  logic                          led;
  logic [CntW-1:0]               pattern_length;

  modport source (output valid, output status, output led, output pattern_length, input ready);
  modport sink (input valid, input status, input led, input pattern_length, output ready);
endinterface

`default_nettype wire

@@ hdl/knpat_store.sv @@
// Interval memory with one write port and one registered read port.
`default_nettype none

module knpat_store #(
  parameter int DEPTH  = knpat_pkg::MAX_INTERVALS_DEF,
  parameter int ADDR_W = $clog2(knpat_pkg::MAX_INTERVALS_DEF)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [ADDR_W-1:0]            waddr_i,
  input  wire logic [knpat_pkg::TICK_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]            raddr_i,
  output      logic [knpat_pkg::TICK_W-1:0] rdata_o
);

  logic [knpat_pkg::TICK_W-1:0] mem_q [DEPTH];
  logic [knpat_pkg::TICK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A write to the entry being read is passed straight to the read register.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/knpat_ctrl.sv @@
// Record and check state machines, elapsed tick counter and status decode.
`default_nettype none

module knpat_ctrl #(
  parameter int MAX_INTERVALS = knpat_pkg::MAX_INTERVALS_DEF,
  parameter int PosW          = $clog2(knpat_pkg::MAX_INTERVALS_DEF),
  parameter int CntW          = $clog2(knpat_pkg::MAX_INTERVALS_DEF + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic [knpat_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic                           knock_i,
  input  wire knpat_pkg::cfg_t                cfg_i,
  input  wire logic [knpat_pkg::TICK_W-1:0]   rd_data_i,
  output      logic                           we_o,
  output      logic [PosW-1:0]                waddr_o,
  output      logic [knpat_pkg::TICK_W-1:0]   wdata_o,
  output      logic [PosW-1:0]                raddr_o,
  output      logic [knpat_pkg::STATUS_W-1:0] status_o,
  output      logic                           led_o,
  output      logic [CntW-1:0]                count_o
);

  localparam int TW = knpat_pkg::TICK_W;

  knpat_pkg::rec_phase_e rec_q, rec_d;
  knpat_pkg::chk_phase_e chk_q, chk_d;
  knpat_pkg::status_e    status;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TW-1:0]         elapsed_q, elapsed_d;
  logic                  lamp_q, lamp_d;
  logic                  mark;

  logic            over_to, below_db, chk_db_ok, late, early_ok, last, full;
  logic [CntW-1:0] pos_inc;
  logic [TW:0]     hi_bound, lo_reach;

  assign hi_bound  = {1'b0, rd_data_i} + (TW + 1)'(cfg_i.interval_tolerance);
  assign lo_reach  = {1'b0, elapsed_q} + (TW + 1)'(cfg_i.interval_tolerance);
  assign over_to   = elapsed_q > cfg_i.press_timeout;
  assign below_db  = elapsed_q < TW'(cfg_i.debounce_ticks);
  assign chk_db_ok = elapsed_q >= knpat_pkg::CHECK_DEBOUNCE;
  assign late      = {1'b0, elapsed_q} > hi_bound;
  assign early_ok  = lo_reach >= {1'b0, rd_data_i};
  assign pos_inc   = CntW'(pos_q) + CntW'(1);
  assign last      = pos_inc >= cnt_q;
  assign full      = cnt_q == CntW'(MAX_INTERVALS - 1);

  // Next state.
  always_comb begin
    rec_d   = rec_q;
    chk_d   = chk_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    lamp_d  = lamp_q;
    mark    = 1'b0;
    we_o    = 1'b0;
    if (step_i) begin
      case (cmd_i)
        knpat_pkg::CMD_BEGIN: begin
          cnt_d  = '0;
          rec_d  = knpat_pkg::REC_FIRST;
          lamp_d = 1'b0;
          chk_d  = knpat_pkg::CHK_FIRST;
          pos_d  = '0;
          mark   = 1'b1;
        end
        knpat_pkg::CMD_CHECK: begin
          // A check tick abandons any recording in progress.
          if (rec_q != knpat_pkg::REC_IDLE) begin
            rec_d  = knpat_pkg::REC_IDLE;
            lamp_d = 1'b0;
          end
          if (cnt_q != '0) begin
            case (chk_q)
              knpat_pkg::CHK_FIRST: begin
                if (knock_i) begin
                  mark  = 1'b1;
                  chk_d = knpat_pkg::CHK_RELEASE;
                end
              end
              knpat_pkg::CHK_RELEASE: begin
                if (chk_db_ok && !over_to) begin
                  if (!knock_i) begin
                    chk_d = knpat_pkg::CHK_NEXT;
                  end
                end else if (over_to) begin
                  chk_d = knpat_pkg::CHK_FIRST;
                  pos_d = '0;
                end
              end
              default: begin
                if (late) begin
                  chk_d = knpat_pkg::CHK_FIRST;
                  pos_d = '0;
                end else if (knock_i) begin
                  if (early_ok && !last) begin
                    pos_d = PosW'(pos_inc);
                    mark  = 1'b1;
                    chk_d = knpat_pkg::CHK_RELEASE;
                  end else begin
                    chk_d = knpat_pkg::CHK_FIRST;
                    pos_d = '0;
                  end
                end
              end
            endcase
          end
        end
        default: begin
          case (rec_q)
            knpat_pkg::REC_FIRST: begin
              if (knock_i) begin
                mark   = 1'b1;
                lamp_d = 1'b1;
                rec_d  = knpat_pkg::REC_RELEASE;
              end else if (over_to) begin
                lamp_d = 1'b0;
                rec_d  = knpat_pkg::REC_IDLE;
              end
            end
            knpat_pkg::REC_RELEASE: begin
              if (!below_db) begin
                if (!knock_i) begin
                  lamp_d = 1'b0;
                  rec_d  = knpat_pkg::REC_NEXT;
                end else if (over_to) begin
                  lamp_d = 1'b0;
                  rec_d  = knpat_pkg::REC_IDLE;
                end
              end
            end
            knpat_pkg::REC_NEXT: begin
              if (knock_i) begin
                we_o = 1'b1;
                if (full) begin
                  cnt_d  = '0;
                  lamp_d = 1'b0;
                  rec_d  = knpat_pkg::REC_IDLE;
                end else begin
                  cnt_d  = cnt_q + CntW'(1);
                  lamp_d = 1'b1;
                  mark   = 1'b1;
                  rec_d  = knpat_pkg::REC_RELEASE;
                end
              end else if (over_to) begin
                rec_d = knpat_pkg::REC_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  // Status of the current tick.
  always_comb begin
    status = knpat_pkg::ST_RECORDING;
    case (cmd_i)
      knpat_pkg::CMD_BEGIN: begin
        status = knpat_pkg::ST_RECORDING;
      end
      knpat_pkg::CMD_CHECK: begin
        if (cnt_q == '0) begin
          status = knpat_pkg::ST_NO_PATTERN;
        end else begin
          case (chk_q)
            knpat_pkg::CHK_FIRST: begin
              status = knock_i ? knpat_pkg::ST_CHECKING : knpat_pkg::ST_NO_KNOCKING;
            end
            knpat_pkg::CHK_RELEASE: begin
              if (!(chk_db_ok && !over_to) && over_to) begin
                status = knpat_pkg::ST_FAIL;
              end else begin
                status = knpat_pkg::ST_CHECKING;
              end
            end
            default: begin
              if (late) begin
                status = knpat_pkg::ST_FAIL;
              end else if (!knock_i) begin
                status = knpat_pkg::ST_CHECKING;
              end else if (!early_ok) begin
                status = knpat_pkg::ST_FAIL;
              end else if (last) begin
                status = knpat_pkg::ST_SUCCESS;
              end else begin
                status = knpat_pkg::ST_CHECKING;
              end
            end
          endcase
        end
      end
      default: begin
        case (rec_q)
          knpat_pkg::REC_FIRST: begin
            if (!knock_i && over_to) begin
              status = knpat_pkg::ST_REC_FAILED;
            end
          end
          knpat_pkg::REC_RELEASE: begin
            if (!below_db && knock_i && over_to) begin
              status = knpat_pkg::ST_REC_FAILED;
            end
          end
          knpat_pkg::REC_NEXT: begin
            if (knock_i) begin
              status = full ? knpat_pkg::ST_REC_FAILED : knpat_pkg::ST_RECORDING;
            end else if (over_to) begin
              status = (cnt_q != '0) ? knpat_pkg::ST_REC_DONE : knpat_pkg::ST_REC_FAILED;
            end
          end
          default: begin
            status = knpat_pkg::ST_REC_DONE;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    elapsed_d = elapsed_q;
    if (step_i) begin
      if (mark) begin
        elapsed_d = TW'(1);
      end else if (elapsed_q != knpat_pkg::ELAPSED_MAX) begin
        elapsed_d = elapsed_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q     <= knpat_pkg::REC_IDLE;
      chk_q     <= knpat_pkg::CHK_FIRST;
      pos_q     <= '0;
      cnt_q     <= '0;
      elapsed_q <= '0;
      lamp_q    <= 1'b0;
    end else begin
      rec_q     <= rec_d;
      chk_q     <= chk_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      lamp_q    <= lamp_d;
    end
  end

  // The memory read port follows the position the next tick will use.
  assign waddr_o  = cnt_q[PosW-1:0];
  assign wdata_o  = elapsed_q;
  assign raddr_o  = pos_d;
  assign status_o = status;
  assign led_o    = lamp_d;
  assign count_o  = cnt_d;

  // The lamp is only lit by a recording in progress.
  a_lamp_recording: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lamp_q |-> (rec_q != knpat_pkg::REC_IDLE))
    else $error("lamp lit while recording is idle");

  // The stored count stays below the capacity of the interval memory.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(MAX_INTERVALS))
    else $error("stored interval count out of range");

  // A nonzero check position always points at a stored interval.
  a_pos_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> (CntW'(pos_q) < cnt_q))
    else $error("check position beyond stored pattern");

  // Beginning a recording clears the pattern and arms the first knock.
  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (cmd_i == knpat_pkg::CMD_BEGIN)) |=>
      ((cnt_q == '0) && (rec_q == knpat_pkg::REC_FIRST) && (elapsed_q == TW'(1))))
    else $error("begin command did not reset recording state");

endmodule

`default_nettype wire

@@ hdl/knock_pattern_record_and_match_core.sv @@
// Knock pattern recorder and matcher: one tick transaction in, one result out.
//
// in_i carries one millisecond tick per transaction: a command (check, record or
// begin recording) and the knock sensor level. out_o returns one result per tick:
// the status code, the lamp and the number of stored intervals.
// The configuration port writes the timeout, tolerance and debounce registers at
// any edge where cfg_we_i is high; software writes them only while idle.
//
// A tick passes an input register and a result register: the result register
// loads when the held tick is processed, which waits while out_o is stalled.
// One tick is accepted every cycle while out_o is not stalled;
// each interval check compares the elapsed count with both tolerance bounds of
// the stored interval from the interval memory, whose registered read port is
// steered by the next check position, ready for the following tick.
// When the receiver stalls, the result register holds and the input register
// keeps one more tick; after that in_i.ready drops until out_o is drained.
// Reset clears the pattern count, both phase machines, the elapsed counter and
// the lamp, and loads the default register values; the interval memory is not
// cleared since no entry is read before it is written.
`default_nettype none

module knock_pattern_record_and_match_core #(
  parameter int MAX_INTERVALS = knpat_pkg::MAX_INTERVALS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  knpat_in_if.sink                              in_i,
  knpat_out_if.source                           out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [knpat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [knpat_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PosW = $clog2(MAX_INTERVALS);
  localparam int CntW = $clog2(MAX_INTERVALS + 1);

  knpat_pkg::cfg_t cfg_q;

  logic                           in_valid_q;
  logic [knpat_pkg::CMD_W-1:0]    cmd_q;
  logic                           knock_q;
  logic                           res_valid_q;
  logic [knpat_pkg::STATUS_W-1:0] status_q;
  logic                           led_q;
  logic [CntW-1:0]                count_q;
  logic                           step;

  logic                           mem_we;
  logic [PosW-1:0]                mem_waddr, mem_raddr;
  logic [knpat_pkg::TICK_W-1:0]   mem_wdata, mem_rdata;
  logic [knpat_pkg::STATUS_W-1:0] status_d;
  logic                           led_d;
  logic [CntW-1:0]                count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_timeout      <= knpat_pkg::TIMEOUT_RST;
      cfg_q.interval_tolerance <= knpat_pkg::TOLERANCE_RST;
      cfg_q.debounce_ticks     <= knpat_pkg::DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        knpat_pkg::CFG_PRESS_TIMEOUT: begin
          cfg_q.press_timeout <= cfg_data_i;
        end
        knpat_pkg::CFG_INTERVAL_TOLERANCE: begin
          cfg_q.interval_tolerance <= cfg_data_i[knpat_pkg::TOL_W-1:0];
        end
        knpat_pkg::CFG_DEBOUNCE_TICKS: begin
          cfg_q.debounce_ticks <= cfg_data_i[knpat_pkg::DEBOUNCE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The held tick is processed when the result register is free or drains.
  assign step       = in_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q   <= in_i.command;
      knock_q <= in_i.knock;
    end
    if (step) begin
      status_q <= status_d;
      led_q    <= led_d;
      count_q  <= count_d;
    end
  end

  knpat_ctrl #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .PosW          (PosW),
    .CntW          (CntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cmd_i     (cmd_q),
    .knock_i   (knock_q),
    .cfg_i     (cfg_q),
    .rd_data_i (mem_rdata),
    .we_o      (mem_we),
    .waddr_o   (mem_waddr),
    .wdata_o   (mem_wdata),
    .raddr_o   (mem_raddr),
    .status_o  (status_d),
    .led_o     (led_d),
    .count_o   (count_d)
  );

  knpat_store #(
    .DEPTH  (MAX_INTERVALS),
    .ADDR_W (PosW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid          = res_valid_q;
  assign out_o.status         = status_q;
  assign out_o.led            = led_q;
  assign out_o.pattern_length = count_q;

endmodule

`default_nettype wire

@@ sim/knock_pattern_record_and_match_core_test.sv @@
// Self-checking test of the knock pattern recorder and matcher: knock trains in, results checked.
module knock_pattern_record_and_match_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import knpat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned QUIET_TICKS = 100;

  typedef struct {
    status_e     status;
    logic        led;
    logic [4:0]  length;
  } tick_outcome_t;

  // Tracks the lock state tick by tick and holds the outcomes still owed by the block.
  class knock_lock_model;
    cfg_t                cfg;
    logic [TICK_W-1:0]   interval_mem [MAX_INTERVALS_DEF];
    logic [4:0]          stored_cnt;
    rec_phase_e          rec_phase;
    chk_phase_e          chk_phase;
    logic [3:0]          chk_pos;
    logic [TICK_W-1:0]   elapsed;
    logic                lamp;
    logic                new_reference;
    tick_outcome_t       outcome_fifo[$];
    int unsigned         mismatch_count;

    function new();
      cfg.press_timeout = TIMEOUT_RST;
      cfg.interval_tolerance = TOLERANCE_RST;
      cfg.debounce_ticks = DEBOUNCE_RST;
      foreach (interval_mem[i]) interval_mem[i] = '0;
      stored_cnt = '0;
      rec_phase = REC_IDLE;
      chk_phase = CHK_FIRST;
      chk_pos = '0;
      elapsed = '0;
      lamp = 1'b0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return outcome_fifo.size();
    endfunction

    function void restart_check();
      chk_phase = CHK_FIRST;
      chk_pos = '0;
    endfunction

    function status_e record_step(logic [TICK_W-1:0] d, logic k);
      case (rec_phase)
        REC_FIRST: begin
          if (k) begin
            new_reference = 1'b1;
            lamp = 1'b1;
            rec_phase = REC_RELEASE;
            return ST_RECORDING;
          end
          if (d > cfg.press_timeout) begin
            lamp = 1'b0;
            rec_phase = REC_IDLE;
            return ST_REC_FAILED;
          end
          return ST_RECORDING;
        end
        REC_RELEASE: begin
          if (d < cfg.debounce_ticks) return ST_RECORDING;
          if (!k) begin
            lamp = 1'b0;
            rec_phase = REC_NEXT;
            return ST_RECORDING;
          end
          if (d > cfg.press_timeout) begin
            lamp = 1'b0;
            rec_phase = REC_IDLE;
            return ST_REC_FAILED;
          end
          return ST_RECORDING;
        end
        REC_NEXT: begin
          if (k) begin
            if (stored_cnt < MAX_INTERVALS_DEF) interval_mem[stored_cnt[3:0]] = d;
            stored_cnt = stored_cnt + 5'd1;
            // The pattern is thrown away once it would fill the whole store.
            if (stored_cnt >= MAX_INTERVALS_DEF) begin
              stored_cnt = '0;
              lamp = 1'b0;
              rec_phase = REC_IDLE;
              return ST_REC_FAILED;
            end
            lamp = 1'b1;
            new_reference = 1'b1;
            rec_phase = REC_RELEASE;
            return ST_RECORDING;
          end
          if (d > cfg.press_timeout) begin
            rec_phase = REC_IDLE;
            return (stored_cnt > 0) ? ST_REC_DONE : ST_REC_FAILED;
          end
          return ST_RECORDING;
        end
        default: return ST_REC_DONE;
      endcase
    endfunction

    function status_e check_step(logic [TICK_W-1:0] d, logic k);
      int unsigned s, tol, dd;
      if (stored_cnt == 0) return ST_NO_PATTERN;
      case (chk_phase)
        CHK_FIRST: begin
          if (!k) return ST_NO_KNOCKING;
          new_reference = 1'b1;
          chk_phase = CHK_RELEASE;
          return ST_CHECKING;
        end
        CHK_RELEASE: begin
          if (d >= CHECK_DEBOUNCE && d <= cfg.press_timeout) begin
            if (!k) chk_phase = CHK_NEXT;
          end else if (d > cfg.press_timeout) begin
            restart_check();
            return ST_FAIL;
          end
          return ST_CHECKING;
        end
        default: begin
          s = interval_mem[chk_pos];
          tol = cfg.interval_tolerance;
          dd = d;
          if (dd > s + tol) begin
            restart_check();
            return ST_FAIL;
          end
          if (!k) return ST_CHECKING;
          if (tol > s || dd >= s - tol) begin
            if (chk_pos + 1 < stored_cnt) begin
              chk_pos = chk_pos + 4'd1;
              new_reference = 1'b1;
              chk_phase = CHK_RELEASE;
              return ST_CHECKING;
            end
            restart_check();
            return ST_SUCCESS;
          end
          restart_check();
          return ST_FAIL;
        end
      endcase
    endfunction

    function tick_outcome_t decide_tick(logic [CMD_W-1:0] cmd, logic k);
      logic [TICK_W-1:0] d;
      tick_outcome_t     res;
      d = elapsed;
      new_reference = 1'b0;
      if (cmd == CMD_BEGIN) begin
        stored_cnt = '0;
        rec_phase = REC_FIRST;
        lamp = 1'b0;
        restart_check();
        new_reference = 1'b1;
        res.status = ST_RECORDING;
      end else if (cmd == CMD_CHECK) begin
        // A check tick drops any recording in progress.
        if (rec_phase != REC_IDLE) begin
          rec_phase = REC_IDLE;
          lamp = 1'b0;
        end
        res.status = check_step(d, k);
      end else begin
        res.status = record_step(d, k);
      end
      if (new_reference) elapsed = 16'd1;
      else if (d != ELAPSED_MAX) elapsed = d + 16'd1;
      res.led = lamp;
      res.length = stored_cnt;
      return res;
    endfunction

    function void note_tick(logic [CMD_W-1:0] cmd, logic k);
      outcome_fifo.push_back(decide_tick(cmd, k));
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic led, logic [4:0] length);
      tick_outcome_t due;
      if (outcome_fifo.size() == 0) begin
        $error("result without a pending tick: status %0d led %0d length %0d",
               status, led, length);
        mismatch_count++;
        return;
      end
      due = outcome_fifo.pop_front();
      if (status !== due.status) begin
        $error("status: expected %0d, got %0d", due.status, status);
        mismatch_count++;
      end
      if (led !== due.led) begin
        $error("led: expected %0d, got %0d", due.led, led);
        mismatch_count++;
      end
      if (length !== due.length) begin
        $error("pattern_length: expected %0d, got %0d", due.length, length);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  knpat_in_if  tick_ch ();
  knpat_out_if result_ch ();

  knock_pattern_record_and_match_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  knock_lock_model lock_model = new();

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned ticks_sent = 0;
  int unsigned results_taken = 0;
  int unsigned cycle_count;
  int unsigned round_no;
  int unsigned random_start;
  int unsigned seg_gaps[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic k);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.command <= cmd;
    tick_ch.knock <= k;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    lock_model.note_tick(cmd, k);
    ticks_sent++;
  endtask

  // Presses spaced by the given gaps, each press held for hold ticks, then tail quiet ticks.
  task automatic knock_train(input logic [CMD_W-1:0] cmd, input int unsigned gaps[$],
                             input int unsigned hold, input int unsigned tail);
    for (int i = 0; i <= gaps.size(); i++) begin
      int unsigned quiet;
      quiet = (i < gaps.size()) ? gaps[i] - hold : tail;
      repeat (hold) send_tick(cmd, 1'b1);
      repeat (quiet) send_tick(cmd, 1'b0);
    end
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (lock_model.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned tmo, input int unsigned tol,
                           input int unsigned deb);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PRESS_TIMEOUT;
    cfg_data_i <= CFG_DATA_W'(tmo);
    @(posedge clk_i);
    cfg_idx_i <= CFG_INTERVAL_TOLERANCE;
    cfg_data_i <= CFG_DATA_W'(tol);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DEBOUNCE_TICKS;
    cfg_data_i <= CFG_DATA_W'(deb);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lock_model.cfg.press_timeout = TIMEOUT_W'(tmo);
    lock_model.cfg.interval_tolerance = TOL_W'(tol);
    lock_model.cfg.debounce_ticks = DEBOUNCE_W'(deb);
  endtask

  // One recording followed by an attempt to knock it back, plus a little noise.
  task automatic knock_round();
    int unsigned gaps[$];
    int unsigned probe[$];
    int unsigned n, hold, chold, kind, tmo, tol, j;
    tmo = lock_model.cfg.press_timeout;
    tol = lock_model.cfg.interval_tolerance;
    kind = $urandom_range(0, 9);
    if (kind == 7) n = $urandom_range(15, 16);
    else if (kind == 9) n = 0;
    else n = $urandom_range(1, 4);
    repeat (n) gaps.push_back($urandom_range(52, 95));
    hold = $urandom_range(1, 45);
    chold = $urandom_range(1, 45);
    send_tick(CMD_BEGIN, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 6)) send_tick(CMD_RECORD, 1'b0);
    case (kind)
      6: begin
        // The final press is held past the timeout, which fails the recording.
        knock_train(CMD_RECORD, gaps, hold, 60);
        repeat (tmo + 5) send_tick(CMD_RECORD, 1'b1);
      end
      8: knock_train(CMD_RECORD, gaps, hold, $urandom_range(1, 60));
      default: knock_train(CMD_RECORD, gaps, hold, tmo + $urandom_range(1, 4));
    endcase
    foreach (gaps[i]) begin
      j = ($urandom_range(0, 5) == 0) ? tol + $urandom_range(1, 10) : $urandom_range(0, tol);
      if ($urandom_range(0, 1) == 1) probe.push_back(gaps[i] + j);
      else probe.push_back((gaps[i] > j + 52) ? gaps[i] - j : 52);
    end
    repeat ($urandom_range(0, 4)) send_tick(CMD_CHECK, 1'b0);
    knock_train(CMD_CHECK, probe, chold, $urandom_range(1, 8));
    repeat ($urandom_range(0, 8)) begin
      send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      // Long hold-offs so that the block fills up and stalls its input.
      if (results_taken == 200 || results_taken == 1200) stall = 80;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_ch.valid) @(posedge clk_i);
      lock_model.check_result(result_ch.status, result_ch.led, result_ch.pattern_length);
      results_taken++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("knock_pattern_record_and_match_core_test: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PRESS_TIMEOUT;
    cfg_data_i = '0;
    tick_ch.valid = 1'b0;
    tick_ch.command = CMD_CHECK;
    tick_ch.knock = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed opening with the default register values.
    send_tick(CMD_CHECK, 1'b0);
    send_tick(CMD_CHECK, 1'b1);
    send_tick(CMD_RECORD, 1'b1);
    send_tick(2'd3, 1'b0);
    send_tick(CMD_BEGIN, 1'b1);
    send_tick(CMD_RECORD, 1'b0);
    send_tick(2'd3, 1'b1);
    send_tick(CMD_RECORD, 1'b1);
    send_tick(CMD_CHECK, 1'b0);
    send_tick(CMD_BEGIN, 1'b0);
    send_tick(CMD_CHECK, 1'b1);
    send_tick(CMD_RECORD, 1'b1);
    send_tick(2'd3, 1'b1);
    drain();

    // Wide timeout and tolerance: one long interval, then a stretch of record ticks with random knocks.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_cfg(60000, 10000, 120);
    send_tick(CMD_BEGIN, 1'b0);
    seg_gaps.push_back(180);
    knock_train(CMD_RECORD, seg_gaps, 5, 0);
    send_tick(CMD_CHECK, 1'b1);
    repeat (QUIET_TICKS) send_tick(CMD_RECORD, 1'($urandom_range(0, 1)));
    send_tick(CMD_CHECK, 1'b0);
    send_tick(CMD_CHECK, 1'b0);
    seg_gaps.delete();
    seg_gaps.push_back(60);
    knock_train(CMD_CHECK, seg_gaps, 5, 3);

    random_start = ticks_sent;
    round_no = 0;
    while (ticks_sent - random_start < 1200) begin
      drain();
      if (round_no == 0) write_cfg(100, 0, 0);
      else write_cfg($urandom_range(100, 160), $urandom_range(0, 20), $urandom_range(0, 45));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      knock_round();
      round_no++;
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (lock_model.mismatch_count == 0) begin
      $display("knock_pattern_record_and_match_core_test: done, clean");
    end else begin
      $display("knock_pattern_record_and_match_core_test: done, errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/knpat_pkg.sv
hdl/knpat_in_if.sv
hdl/knpat_out_if.sv
hdl/knpat_store.sv
hdl/knpat_ctrl.sv
hdl/knock_pattern_record_and_match_core.sv
sim/knock_pattern_record_and_match_core_test.sv
